/* rtl/core/bus_frame_receiver_crc_ack_assert.svh */
// Assertion macros for the bus frame receiver.
`ifndef BUS_FRAME_RECEIVER_CRC_ACK_ASSERT_SVH
`define BUS_FRAME_RECEIVER_CRC_ACK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only out of reset
`define BFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BFR_ASSERT_RST(lbl, prop, msg)

`define BFR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/bfr_pkg.sv */
package bfr_pkg;

  localparam int unsigned SILENCE_COUNT_BITS_DEFAULT = 16;

  localparam logic [15:0] CrcPoly           = 16'h1021;
  localparam logic [15:0] SilenceLimitReset = 16'd2604;
  localparam logic [15:0] LocalMaskReset    = 16'h0000;
  localparam logic [3:0]  AckLowNibble      = 4'hA;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned RegIdxLsb = 2;

  typedef enum logic [0:0] {
    REG_SILENCE_LIMIT   = 1'b0,
    REG_LOCAL_NODE_MASK = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_DEST = 3'd1,
    PH_DATA = 3'd2,
    PH_CRC  = 3'd3,
    PH_ACK  = 3'd4,
    PH_SKIP = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_LEN = 2'd1,
    ERR_CRC_HIGH = 2'd2,
    ERR_CRC_LOW  = 2'd3
  } err_e;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic       sink_full;
  } bfr_in_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [7:0] frame_dest;
    logic [7:0] frame_length;
    logic [1:0] error_code;
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic [2:0] parser_phase;
  } bfr_out_t;

  typedef struct packed {
    logic [15:0] silence_limit;
    logic [15:0] local_node_mask;
  } bfr_cfg_t;

  // CRC-16, poly 0x1021, one byte MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/bfr_stream_if.sv */
interface bfr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/bfr_apb_regs.sv */
module bfr_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfr_pkg::ApbAddrW-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output bfr_pkg::bfr_cfg_t               cfg_o
);
  import bfr_pkg::*;

  logic [15:0] silence_limit_q;
  logic [15:0] local_node_mask_q;
  reg_idx_e    idx;
  logic        wr_en;

  assign idx    = reg_idx_e'(paddr[RegIdxLsb]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_limit_q   <= SilenceLimitReset;
      local_node_mask_q <= LocalMaskReset;
    end else if (wr_en) begin
      case (idx)
        REG_SILENCE_LIMIT:   silence_limit_q   <= pwdata[15:0];
        REG_LOCAL_NODE_MASK: local_node_mask_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SILENCE_LIMIT:   prdata = {16'h0000, silence_limit_q};
      REG_LOCAL_NODE_MASK: prdata = {16'h0000, local_node_mask_q};
      default:             prdata = 32'h0;
    endcase
  end

  assign cfg_o.silence_limit   = silence_limit_q;
  assign cfg_o.local_node_mask = local_node_mask_q;
endmodule

/* rtl/core/bfr_parser.sv */
module bfr_parser #(
  parameter int unsigned SILENCE_COUNT_BITS = bfr_pkg::SILENCE_COUNT_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bfr_pkg::bfr_in_t  item_i,
  input  bfr_pkg::bfr_cfg_t cfg_i,
  output bfr_pkg::bfr_out_t result_o
);
  import bfr_pkg::*;

  localparam int unsigned CntW = SILENCE_COUNT_BITS;
  localparam int unsigned CmpW = (CntW > 16) ? CntW : 16;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  phase_e         phase_q, phase_d;
  logic [7:0]     length_q, length_d;
  logic [7:0]     dest_q, dest_d;
  logic [7:0]     count_q, count_d;
  logic [15:0]    crc_q, crc_d;
  logic           crc_hi_q, crc_hi_d;
  logic           local_q, local_d;
  logic [CntW-1:0] sil_q, sil_d;

  logic [7:0]     b;
  logic [15:0]    crc_in;
  logic [15:0]    crc_upd;

  assign b       = item_i.rx_byte;
  // a length byte restarts the CRC from zero
  assign crc_in  = (phase_q == PH_LEN) ? 16'h0000 : crc_q;
  assign crc_upd = crc16_byte(crc_in, b);

  // next state
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    dest_d   = dest_q;
    count_d  = count_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    local_d  = local_q;
    sil_d    = sil_q;
    if (op_e'(item_i.operation) == OP_TICK) begin
      sil_d = (sil_q != CntMax) ? sil_q + 1'b1 : sil_q;
      if (CmpW'(sil_d) > CmpW'(cfg_i.silence_limit)) phase_d = PH_LEN;
    end else begin
      sil_d = '0;
      case (phase_q)
        PH_LEN: begin
          if (b == 8'h00) begin
            phase_d = PH_SKIP;
          end else begin
            length_d = b;
            count_d  = 8'h00;
            crc_d    = crc_upd;
            crc_hi_d = 1'b0;
            phase_d  = PH_DEST;
          end
        end
        PH_DEST: begin
          dest_d  = b;
          crc_d   = crc_upd;
          local_d = cfg_i.local_node_mask[b[7:4]];
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          count_d = count_q + 8'd1;
          crc_d   = crc_upd;
          if (count_d >= length_q) phase_d = PH_CRC;
        end
        PH_CRC: begin
          if (!crc_hi_q) begin
            if (b != crc_q[15:8]) phase_d = PH_SKIP;
            else crc_hi_d = 1'b1;
          end else if (b != crc_q[7:0]) begin
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_ACK;
          end
        end
        default: phase_d = PH_SKIP;
      endcase
    end
  end

  // result fields
  always_comb begin
    result_o               = '0;
    result_o.frame_dest    = dest_d;
    result_o.frame_length  = length_d;
    result_o.parser_phase  = phase_d;
    result_o.error_code    = ERR_NONE;
    if (op_e'(item_i.operation) == OP_BYTE) begin
      case (phase_q)
        PH_LEN: begin
          if (b == 8'h00) result_o.error_code = ERR_ZERO_LEN;
        end
        PH_DATA: begin
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = b;
        end
        PH_CRC: begin
          if (!crc_hi_q) begin
            if (b != crc_q[15:8]) result_o.error_code = ERR_CRC_HIGH;
          end else if (b != crc_q[7:0]) begin
            result_o.error_code = ERR_CRC_LOW;
          end else begin
            result_o.frame_done = 1'b1;
            if (local_q && !item_i.sink_full) begin
              result_o.ack_valid = 1'b1;
              result_o.ack_byte  = {dest_q[7:4], AckLowNibble};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      length_q <= 8'h00;
      dest_q   <= 8'h00;
      count_q  <= 8'h00;
      crc_q    <= 16'h0000;
      crc_hi_q <= 1'b0;
      local_q  <= 1'b0;
      sil_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      dest_q   <= dest_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      local_q  <= local_d;
      sil_q    <= sil_d;
    end
  end
endmodule

/* rtl/core/bfr_out_reg.sv */
module bfr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bfr_pkg::bfr_out_t result_i,
  output logic              space_o,
  bfr_stream_if.source      out_o
);
  import bfr_pkg::*;

  logic     valid_q;
  bfr_out_t data_q;

  // room when empty or the held beat leaves this cycle
  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= result_i;
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = data_q;
endmodule

/* rtl/core/bus_frame_receiver_crc_ack.sv */
// Channel   Dir  Payload                                   Beat
// in_i      in   operation, rx_byte, sink_full             one byte or one tick
// out_o     out  payload/frame/error/ack/phase fields      one result per input beat
// apb       in   silence_limit @0x0, local_node_mask @0x4  one register write
//
// One input beat per cycle while out_o takes results, one result per beat; the path runs
// through the input register, then parse and CRC byte update into the result register.
// rst_ni is asynchronous: parser back to waiting for length, registers to defaults.
// A stalled out_o holds the result register; the input register then fills
// and in_i.ready drops until the result is taken.
module bus_frame_receiver_crc_ack #(
  parameter int unsigned SILENCE_COUNT_BITS = bfr_pkg::SILENCE_COUNT_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bfr_stream_if.sink                   in_i,
  bfr_stream_if.source                 out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfr_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bfr_pkg::*;

  `include "bus_frame_receiver_crc_ack_assert.svh"

  bfr_cfg_t cfg;
  bfr_in_t  item_q;
  logic     item_valid_q;
  logic     out_space;
  logic     step;
  bfr_out_t result;

  assign step       = item_valid_q && out_space;
  assign in_i.ready = !item_valid_q || out_space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (step) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) item_q <= in_i.payload;
  end

  bfr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bfr_parser #(
    .SILENCE_COUNT_BITS (SILENCE_COUNT_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  bfr_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (result),
    .space_o  (out_space),
    .out_o    (out_o)
  );

  `BFR_ASSERT_RST(a_ack_needs_done, out_o.valid && out_o.payload.ack_valid |-> out_o.payload.frame_done, "ack without good frame")
  `BFR_ASSERT_RST(a_err_to_skip, out_o.valid && (out_o.payload.error_code != ERR_NONE) |-> (out_o.payload.parser_phase == PH_SKIP), "error did not enter skip")
  `BFR_ASSERT_RST(a_payload_phase, out_o.valid && out_o.payload.payload_valid |-> (out_o.payload.parser_phase == PH_DATA) || (out_o.payload.parser_phase == PH_CRC), "data beat outside data phase")
  `BFR_ASSERT_ALWAYS(a_no_overrun, item_valid_q && out_o.valid && !out_o.ready |-> !in_i.ready, "input taken with no room")
endmodule
